### hdl/srat_pkg.sv
// shared types and constants for the section range address translator
package srat_pkg;

	localparam int ADDR_W  = 32;
	localparam int SIDX_W  = 6;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 7;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] REG_MODULE_BASE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SECTION_COUNT = 2'd1;

	typedef enum logic {
		OP_WRITE     = 1'b0,
		OP_TRANSLATE = 1'b1
	} srat_op_t;

	// one word traveling down the cell chain
	typedef struct packed {
		logic              valid;
		srat_op_t          op;
		logic [SIDX_W-1:0] widx;
		logic [ADDR_W-1:0] wstart;
		logic [ADDR_W-1:0] wsize;
		logic [ADDR_W-1:0] woff;
		logic [ADDR_W-1:0] addr;
		logic              hint_valid;
		logic [SIDX_W-1:0] hint_idx;
		logic              hint_hit;
		logic [ADDR_W-1:0] hint_xlat;
		logic              hit;
		logic [SIDX_W-1:0] hit_idx;
		logic [ADDR_W-1:0] hit_xlat;
	} srat_tok_t;

endpackage

### hdl/section_range_address_translator_top.sv
// each accepted word passes through the cell registers in chain order, then the result register
// throughput: one word per cycle; the whole chain advances together and holds
// while a finished result waits on out_stall
// write words travel the chain in order, so later lookups see earlier writes
// reset clears configuration registers and chain valid state; table entries are undefined until written
// top level: configuration registers, cell chain and result register
module section_range_address_translator_top import srat_pkg::*; #(
	parameter int MAX_SECTIONS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [SIDX_W-1:0] entry_index,
	input  logic [ADDR_W-1:0] entry_start,
	input  logic [ADDR_W-1:0] entry_size,
	input  logic [ADDR_W-1:0] entry_file_offset,
	input  logic [ADDR_W-1:0] lookup_address,
	input  logic              hint_valid,
	input  logic [SIDX_W-1:0] hint_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [SIDX_W-1:0] section_index,
	output logic [ADDR_W-1:0] translated_address
);

	logic [ADDR_W-1:0] module_base_q;
	logic [CNT_W-1:0]  section_count_q;
	logic              adv;
	srat_tok_t         tok [0:MAX_SECTIONS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_base_q   <= '0;
			section_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULE_BASE:   module_base_q   <= cfg_data;
				REG_SECTION_COUNT: section_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tok[0]            = '0;
		tok[0].valid      = in_valid;
		tok[0].op         = srat_op_t'(operation);
		tok[0].widx       = entry_index;
		tok[0].wstart     = entry_start;
		tok[0].wsize      = entry_size;
		tok[0].woff       = entry_file_offset;
		tok[0].addr       = lookup_address;
		tok[0].hint_valid = hint_valid;
		tok[0].hint_idx   = hint_index;
	end

	assign in_stall = !adv;

	for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
		srat_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.adv           (adv),
			.module_base   (module_base_q),
			.section_count (section_count_q),
			.tok_in        (tok[i]),
			.tok_out       (tok[i+1])
		);
	end

	srat_out u_out (
		.clk                (clk),
		.arst_n             (arst_n),
		.tok_in             (tok[MAX_SECTIONS]),
		.out_stall          (out_stall),
		.adv                (adv),
		.out_valid          (out_valid),
		.found              (found),
		.section_index      (section_index),
		.translated_address (translated_address)
	);

`ifndef SYNTHESIS
	// input only backs up when a finished result is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// a new result only comes from a translate word at the chain tail
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(tok[MAX_SECTIONS].valid
		                           && (tok[MAX_SECTIONS].op == OP_TRANSLATE)))
		else $error("result without a translate word");

	// a miss reports zero index and zero address
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (section_index == '0 && translated_address == '0))
		else $error("miss with nonzero payload");
`endif

endmodule

### hdl/srat_cell.sv
// one table entry of the chain: stores a section and checks each passing word
module srat_cell import srat_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [ADDR_W-1:0] module_base,
	input  logic [CNT_W-1:0]  section_count,
	input  srat_tok_t         tok_in,
	output srat_tok_t         tok_out
);

	localparam logic [IDX_W-1:0]  ME     = IDX_W'(CELL_IDX);
	localparam logic [SIDX_W-1:0] ME_OUT = SIDX_W'(CELL_IDX);

	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] off_q;
	srat_tok_t         tok_q;

	logic              is_xlat;
	logic              holds;
	logic [ADDR_W:0]   end_ext;
	logic [ADDR_W-1:0] xlat;
	logic              hint_me;
	logic              in_range;
	srat_tok_t         tok_nxt;

	assign is_xlat  = tok_in.valid && (tok_in.op == OP_TRANSLATE);
	// end bound at 33 bits so it never wraps
	assign end_ext  = {1'b0, start_q} + {1'b0, size_q};
	assign holds    = (tok_in.addr >= start_q) && ({1'b0, tok_in.addr} < end_ext);
	assign xlat     = module_base + off_q + (tok_in.addr - start_q);
	assign hint_me  = tok_in.hint_valid && ({1'b0, tok_in.hint_idx} == ME);
	assign in_range = ME < IDX_W'(section_count);

	always_comb begin
		tok_nxt = tok_in;
		if (is_xlat && hint_me && holds) begin
			tok_nxt.hint_hit  = 1'b1;
			tok_nxt.hint_xlat = xlat;
		end
		if (is_xlat && in_range && holds && !tok_in.hit) begin
			tok_nxt.hit      = 1'b1;
			tok_nxt.hit_idx  = ME_OUT;
			tok_nxt.hit_xlat = xlat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.valid && (tok_in.op == OP_WRITE)
		    && ({1'b0, tok_in.widx} == ME)) begin
			start_q <= tok_in.wstart;
			size_q  <= tok_in.wsize;
			off_q   <= tok_in.woff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

### hdl/srat_out.sv
// result register at the end of the chain: picks the hint match first, else the search match, else a miss
module srat_out import srat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  srat_tok_t         tok_in,
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output logic              found,
	output logic [SIDX_W-1:0] section_index,
	output logic [ADDR_W-1:0] translated_address
);

	logic              vld_q;
	logic              found_q;
	logic [SIDX_W-1:0] idx_q;
	logic [ADDR_W-1:0] xlat_q;
	logic              load;

	assign adv  = !vld_q || !out_stall;
	assign load = adv && tok_in.valid && (tok_in.op == OP_TRANSLATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_in.valid && (tok_in.op == OP_TRANSLATE);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (tok_in.hint_hit) begin
				found_q <= 1'b1;
				idx_q   <= tok_in.hint_idx;
				xlat_q  <= tok_in.hint_xlat;
			end else if (tok_in.hit) begin
				found_q <= 1'b1;
				idx_q   <= tok_in.hit_idx;
				xlat_q  <= tok_in.hit_xlat;
			end else begin
				found_q <= 1'b0;
				idx_q   <= '0;
				xlat_q  <= '0;
			end
		end
	end

	assign out_valid          = vld_q;
	assign found              = found_q;
	assign section_index      = idx_q;
	assign translated_address = xlat_q;

endmodule
